>>> hdl/hkbm_pkg.sv
// hkbm_pkg: request kinds, answer codes, field widths and defaults for the
// hashed key binary search tree map
// no dependencies
package hkbm_pkg;

   // field widths
   localparam int KEY_W    = 32;
   localparam int VAL_W    = 16;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;

   // default node count of the tree store
   localparam int NODES_DEFAULT = 1024;

   // request kinds
   localparam logic [KIND_W-1:0] REQ_LOOKUP = 2'd0;
   localparam logic [KIND_W-1:0] REQ_INSERT = 2'd1;
   localparam logic [KIND_W-1:0] REQ_CLEAR  = 2'd2;

   // answer codes
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

endpackage

>>> hdl/hashed_key_bst_map.sv
// hashed_key_bst_map: key to value map kept as a binary search tree in one
// node memory, walked one level per cycle
// depends on hkbm_pkg
//
// Usage:
//  - req channel: req_tuser carries the request kind (lookup, insert, clear),
//    req_tdata carries the 32-bit hashed key and the 16-bit value.
//  - rsp channel: one word per request; rsp_tuser carries the status
//    (ok, lookup miss, table full), rsp_tdata the value found on a hit.
//  - a lookup or an insert walks the tree from the root, one node memory
//    read per level below the root; an insert that links a new node also
//    passes through a link state, and a clear or the unused request code
//    answers without a walk. The block goes back to idle after loading the
//    answer and takes a new request only there, so it takes no new request
//    before the last one has loaded its answer.
//  - the root node lives in flip-flops; nodes 1 .. NODES-1 live in memory
//    and are written whole when linked, so memory needs no clearing.
//  - reset empties the tree (root key 0, value 0, no children) and sets the
//    allocator to node 1; the block is ready in the first cycle after reset.
//  - the answer waits in an output register while rsp_tready is low; the
//    next request is still accepted and walks, and is held before its answer
//    until the output register is free.
module hashed_key_bst_map #(
   parameter int NODES = hkbm_pkg::NODES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // key [31:0], value [47:32]
   input  logic [1:0]  req_tuser,   // req_type [1:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // value_res [15:0]
   output logic [1:0]  rsp_tuser    // status [1:0]
);

   localparam int IDX_W = (NODES > 2) ? $clog2(NODES) : 1;
   localparam int NF_W  = IDX_W + 1;

   localparam int KEY_W    = hkbm_pkg::KEY_W;
   localparam int VAL_W    = hkbm_pkg::VAL_W;
   localparam int KIND_W   = hkbm_pkg::KIND_W;
   localparam int STATUS_W = hkbm_pkg::STATUS_W;

   // states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EVAL = 2'd1;
   localparam logic [1:0] S_LINK = 2'd2;
   localparam logic [1:0] S_RESP = 2'd3;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
      logic [VAL_W-1:0] value;
   } node_type;

   // node memory, entry 0 unused (root is in flip-flops)
   node_type node_mem [NODES];

   logic [1:0]          state_ff, state_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [VAL_W-1:0]    value_ff, value_in;
   logic [IDX_W-1:0]    cur_ff, cur_in;
   logic [IDX_W-1:0]    alloc_ff, alloc_in;
   logic [NF_W-1:0]     next_free_ff, next_free_in;
   node_type            root_ff, root_in;
   node_type            rdata_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [VAL_W-1:0]    res_ff, res_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [VAL_W-1:0]    rsp_value_ff;

   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   node_type            wr_data;
   logic                rsp_load;
   node_type            node;
   node_type            upd;
   logic                go_left;
   logic [IDX_W-1:0]    nxt;
   logic                req_acc;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

   // node under inspection: root from flip-flops, others from memory
   assign node    = (cur_ff == '0) ? root_ff : rdata_ff;
   assign go_left = key_ff < node.key;
   assign nxt     = go_left ? node.left : node.right;

   // walk control
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      cur_in       = cur_ff;
      alloc_in     = alloc_ff;
      next_free_in = next_free_ff;
      root_in      = root_ff;
      status_in    = status_ff;
      res_in       = res_ff;
      rd_en        = 1'b0;
      rd_addr      = nxt;
      wr_en        = 1'b0;
      wr_addr      = cur_ff;
      upd          = node;
      wr_data      = node;
      rsp_load     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in   = req_tuser;
               key_in    = req_tdata[KEY_W-1:0];
               value_in  = req_tdata[KEY_W+VAL_W-1:KEY_W];
               cur_in    = '0;
               status_in = hkbm_pkg::STATUS_OK;
               res_in    = '0;
               case (req_tuser)
                  hkbm_pkg::REQ_LOOKUP, hkbm_pkg::REQ_INSERT: begin
                     state_in = S_EVAL;
                  end
                  hkbm_pkg::REQ_CLEAR: begin
                     root_in      = '0;
                     next_free_in = NF_W'(1);
                     state_in     = S_RESP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_EVAL: begin
            if (node.key == key_ff) begin
               // hit: lookup returns the value, insert updates it
               status_in = hkbm_pkg::STATUS_OK;
               state_in  = S_RESP;
               if (kind_ff == hkbm_pkg::REQ_INSERT) begin
                  res_in    = '0;
                  upd.value = value_ff;
                  wr_data   = upd;
                  if (cur_ff == '0) begin
                     root_in = upd;
                  end else begin
                     wr_en = 1'b1;
                  end
               end else begin
                  res_in = node.value;
               end
            end else if (nxt != '0) begin
               // descend one level
               cur_in = nxt;
               rd_en  = 1'b1;
            end else if (kind_ff == hkbm_pkg::REQ_LOOKUP) begin
               status_in = hkbm_pkg::STATUS_MISS;
               res_in    = '0;
               state_in  = S_RESP;
            end else if (next_free_ff >= NF_W'(NODES)) begin
               status_in = hkbm_pkg::STATUS_FULL;
               res_in    = '0;
               state_in  = S_RESP;
            end else begin
               // link a fresh node under the last node visited
               if (go_left) begin
                  upd.left = next_free_ff[IDX_W-1:0];
               end else begin
                  upd.right = next_free_ff[IDX_W-1:0];
               end
               wr_data = upd;
               if (cur_ff == '0) begin
                  root_in = upd;
               end else begin
                  wr_en = 1'b1;
               end
               alloc_in     = next_free_ff[IDX_W-1:0];
               next_free_in = next_free_ff + NF_W'(1);
               status_in    = hkbm_pkg::STATUS_OK;
               res_in       = '0;
               state_in     = S_LINK;
            end
         end
         S_LINK: begin
            // write the new node whole, with no children
            wr_en         = 1'b1;
            wr_addr       = alloc_ff;
            wr_data.key   = key_ff;
            wr_data.left  = '0;
            wr_data.right = '0;
            wr_data.value = value_ff;
            state_in      = S_RESP;
         end
         S_RESP: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output word register
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   // node memory: reads and writes never fall in the same cycle, since a
   // write only ends a walk and the next walk starts at the root
   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= node_mem[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         next_free_ff  <= NF_W'(1);
         root_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_free_ff  <= next_free_in;
         root_ff       <= root_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      key_ff    <= key_in;
      value_ff  <= value_in;
      cur_ff    <= cur_in;
      alloc_ff  <= alloc_in;
      status_ff <= status_in;
      res_ff    <= res_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_value_ff  <= res_ff;
      end
   end

   // allocator never runs past the node count
   assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= NF_W'(NODES) && next_free_ff != '0)
      else $error("allocator out of range");

   // a clear resets the allocator by the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tuser == hkbm_pkg::REQ_CLEAR) |=> next_free_ff == NF_W'(1))
      else $error("clear did not reset allocator");

   // memory never writes the root slot and never reads while writing
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (!rd_en && wr_addr != '0))
      else $error("bad node memory access");

   // full is only reported when every node is taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_load && status_ff == hkbm_pkg::STATUS_FULL) |-> next_free_ff == NF_W'(NODES))
      else $error("full reported with free nodes");

   // an accepted request always leaves the idle state
   assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff != S_IDLE)
      else $error("request accepted but not started");

endmodule
